/* src/ale_pkg.sv */
// ale_pkg: shared types, codes and constants for the ansi line editor
// used by every module of the block; depends on nothing
package ale_pkg;

    typedef enum logic [2:0] {
        FUNC_BYTE   = 3'd0,
        FUNC_TICK   = 3'd1,
        FUNC_ARM    = 3'd2,
        FUNC_CANCEL = 3'd3,
        FUNC_READ   = 3'd4
    } func_t;

    typedef enum logic [3:0] {
        ACT_NONE    = 4'd0,
        ACT_LEFT    = 4'd1,
        ACT_RIGHT   = 4'd2,
        ACT_DELETE  = 4'd3,
        ACT_BACK    = 4'd4,
        ACT_INSERT  = 4'd5,
        ACT_LINE    = 4'd6,
        ACT_CTRL    = 4'd7,
        ACT_TIMEOUT = 4'd8,
        ACT_READ    = 4'd9
    } action_t;

    typedef enum logic [2:0] {
        ESC_C0   = 3'd0,
        ESC_FE   = 3'd1,
        ESC_SS2  = 3'd2,
        ESC_SS3  = 3'd3,
        ESC_CSI  = 3'd4,
        ESC_PRIV = 3'd5
    } esc_t;

    // edit operations the controller hands to the datapath
    typedef enum logic [3:0] {
        OP_NONE   = 4'd0,
        OP_LEFT   = 4'd1,
        OP_RIGHT  = 4'd2,
        OP_WLEFT  = 4'd3,
        OP_WRIGHT = 4'd4,
        OP_DEL    = 4'd5,
        OP_BACK   = 4'd6,
        OP_INSERT = 4'd7,
        OP_CTRL   = 4'd8,
        OP_ARM    = 4'd9,
        OP_READ   = 4'd10
    } op_t;

    localparam logic [1:0] REG_LINE_SIZE  = 2'd0;
    localparam logic [1:0] REG_CTRL_MASK  = 2'd1;
    localparam logic [1:0] REG_IDLE_LIMIT = 2'd2;

    localparam logic [7:0] CH_BS  = 8'd8;
    localparam logic [7:0] CH_CR  = 8'd13;
    localparam logic [7:0] CH_CAN = 8'd24;
    localparam logic [7:0] CH_ESC = 8'd27;
    localparam logic [7:0] CH_DEL = 8'd127;
    localparam logic [7:0] CH_SP  = 8'd32;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] data;
        logic [7:0] index;
    } in_item_t;

    typedef struct packed {
        logic [3:0] action;
        logic [8:0] count;
        logic [7:0] char_value;
        logic [7:0] line_length;
        logic [7:0] cursor;
        logic       active;
    } out_item_t;

    // command from controller to datapath
    typedef struct packed {
        logic       start;
        op_t        op;
        logic [8:0] amount;
        logic [7:0] ch;
        logic [7:0] index;
    } dp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic       done;
        action_t    action;
        logic [8:0] count;
        logic [7:0] ch;
        logic [7:0] length;
        logic [7:0] cursor;
    } dp_stat_t;

endpackage

/* src/ale_datapath.sv */
// ale_datapath: line store memory, length and cursor, and the serial shift and scan engine
// depends on ale_pkg
module ale_datapath
    import ale_pkg::*;
#(
    parameter int LINE_DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [8:0] capacity,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat
);
    localparam int AW = $clog2(LINE_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_INS, S_REM, S_WR_RD, S_WR_CHK, S_WL_RD, S_WL_CHK, S_READ, S_DONE
    } st_t;

    logic [7:0] mem [LINE_DEPTH];
    logic [7:0] rdata_reg;
    logic [AW-1:0] raddr;
    logic          rd_en;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;

    st_t        st_reg, st_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cur_reg, cur_next;
    logic [8:0] ptr_reg, ptr_next;
    logic [8:0] n_reg, n_next;
    logic [7:0] ch_reg, ch_next;
    logic [7:0] prev_reg, prev_next;
    action_t    act_reg, act_next;
    logic [8:0] cnt_reg, cnt_next;
    logic [7:0] och_reg, och_next;
    logic       phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= S_IDLE;
            len_reg <= '0;
            cur_reg <= '0;
        end else begin
            st_reg  <= st_next;
            len_reg <= len_next;
            cur_reg <= cur_next;
        end
        ptr_reg   <= ptr_next;
        n_reg     <= n_next;
        ch_reg    <= ch_next;
        prev_reg  <= prev_next;
        act_reg   <= act_next;
        cnt_reg   <= cnt_next;
        och_reg   <= och_next;
        phase_reg <= phase_next;
    end

    logic [8:0] room;
    assign room = {1'b0, len_reg} - {1'b0, cur_reg};

    always_comb begin
        st_next    = st_reg;
        len_next   = len_reg;
        cur_next   = cur_reg;
        ptr_next   = ptr_reg;
        n_next     = n_reg;
        ch_next    = ch_reg;
        prev_next  = prev_reg;
        act_next   = act_reg;
        cnt_next   = cnt_reg;
        och_next   = och_reg;
        phase_next = phase_reg;
        rd_en = 1'b0;
        raddr = ptr_reg[AW-1:0];
        we    = 1'b0;
        waddr = ptr_reg[AW-1:0];
        wdata = ch_reg;
        case (st_reg)
            S_IDLE: begin
                if (cmd.start) begin
                    act_next = ACT_NONE;
                    cnt_next = '0;
                    och_next = '0;
                    n_next   = '0;
                    st_next  = S_DONE;
                    case (cmd.op)
                        OP_LEFT: begin
                            if (cmd.amount > {1'b0, cur_reg}) begin
                                n_next = {1'b0, cur_reg};
                            end else begin
                                n_next = cmd.amount;
                            end
                            if (cmd.amount != 9'd0 && cur_reg != 8'd0) begin
                                act_next = ACT_LEFT;
                                cnt_next = (cmd.amount > {1'b0, cur_reg}) ?
                                    {1'b0, cur_reg} : cmd.amount;
                                cur_next = cur_reg - ((cmd.amount > {1'b0, cur_reg}) ?
                                    cur_reg : cmd.amount[7:0]);
                            end
                        end
                        OP_RIGHT: begin
                            if (cmd.amount != 9'd0 && room != 9'd0) begin
                                act_next = ACT_RIGHT;
                                cnt_next = (cmd.amount > room) ? room : cmd.amount;
                                cur_next = cur_reg + ((cmd.amount > room) ?
                                    room[7:0] : cmd.amount[7:0]);
                            end
                        end
                        OP_WRIGHT: begin
                            if (cur_reg < len_reg) begin
                                st_next = S_WR_RD;
                            end
                        end
                        OP_WLEFT: begin
                            if (cur_reg != 8'd0) begin
                                st_next = S_WL_RD;
                            end
                        end
                        OP_DEL: begin
                            if (len_reg != 8'd0 && cur_reg < len_reg) begin
                                act_next = ACT_DELETE;
                                len_next = len_reg - 8'd1;
                                ptr_next = {1'b0, cur_reg};
                                phase_next = 1'b0;
                                st_next  = S_REM;
                            end
                        end
                        OP_BACK: begin
                            if (cur_reg != 8'd0 && len_reg != 8'd0) begin
                                act_next = ACT_BACK;
                                cur_next = cur_reg - 8'd1;
                                len_next = len_reg - 8'd1;
                                ptr_next = {1'b0, cur_reg - 8'd1};
                                phase_next = 1'b0;
                                st_next  = S_REM;
                            end
                        end
                        OP_INSERT: begin
                            if ({1'b0, len_reg} < capacity) begin
                                act_next = ACT_INSERT;
                                och_next = cmd.ch;
                                cnt_next = room + 9'd1;
                                ch_next  = cmd.ch;
                                ptr_next = {1'b0, len_reg};
                                phase_next = 1'b0;
                                st_next  = S_INS;
                            end
                        end
                        OP_CTRL: begin
                            act_next = ACT_CTRL;
                            och_next = cmd.ch;
                            len_next = 8'd1;
                            we    = 1'b1;
                            waddr = '0;
                            wdata = cmd.ch;
                        end
                        OP_ARM: begin
                            len_next = '0;
                            cur_next = '0;
                        end
                        OP_READ: begin
                            act_next = ACT_READ;
                            if ({1'b0, cmd.index} < 9'(LINE_DEPTH)) begin
                                rd_en = 1'b1;
                                raddr = AW'(cmd.index);
                                st_next = S_READ;
                            end
                        end
                        default: begin
                            act_next = ACT_NONE;
                        end
                    endcase
                end
            end
            S_READ: begin
                och_next = rdata_reg;
                st_next  = S_DONE;
            end
            // move bytes up one place from the end down to the cursor
            S_INS: begin
                if (ptr_reg[7:0] == cur_reg) begin
                    we    = 1'b1;
                    wdata = ch_reg;
                    len_next = len_reg + 8'd1;
                    cur_next = cur_reg + 8'd1;
                    st_next  = S_DONE;
                end else if (!phase_reg) begin
                    rd_en = 1'b1;
                    raddr = AW'(ptr_reg - 9'd1);
                    phase_next = 1'b1;
                end else begin
                    we    = 1'b1;
                    wdata = rdata_reg;
                    ptr_next = ptr_reg - 9'd1;
                    phase_next = 1'b0;
                end
            end
            // move bytes down one place toward the removed position
            S_REM: begin
                if (ptr_reg >= {1'b0, len_reg}) begin
                    st_next = S_DONE;
                end else if (!phase_reg) begin
                    rd_en = 1'b1;
                    raddr = AW'(ptr_reg + 9'd1);
                    phase_next = 1'b1;
                end else begin
                    we    = 1'b1;
                    wdata = rdata_reg;
                    ptr_next = ptr_reg + 9'd1;
                    phase_next = 1'b0;
                end
            end
            S_WR_RD: begin
                n_next   = n_reg + 9'd1;
                cur_next = cur_reg + 8'd1;
                if (cur_reg + 8'd1 >= len_reg) begin
                    act_next = ACT_RIGHT;
                    cnt_next = n_reg + 9'd1;
                    st_next  = S_DONE;
                end else begin
                    rd_en = 1'b1;
                    raddr = AW'(cur_reg);
                    phase_next = 1'b0;
                    st_next = S_WR_CHK;
                end
            end
            S_WR_CHK: begin
                if (!phase_reg) begin
                    prev_next = rdata_reg;
                    rd_en = 1'b1;
                    raddr = AW'(cur_reg);
                    phase_next = 1'b1;
                end else if (rdata_reg == CH_SP && prev_reg != CH_SP) begin
                    act_next = ACT_RIGHT;
                    cnt_next = n_reg;
                    st_next  = S_DONE;
                end else begin
                    st_next = S_WR_RD;
                end
            end
            S_WL_RD: begin
                n_next   = n_reg + 9'd1;
                cur_next = cur_reg - 8'd1;
                if (cur_reg == 8'd1) begin
                    act_next = ACT_LEFT;
                    cnt_next = n_reg + 9'd1;
                    st_next  = S_DONE;
                end else begin
                    rd_en = 1'b1;
                    raddr = AW'(cur_reg - 8'd1);
                    phase_next = 1'b0;
                    st_next = S_WL_CHK;
                end
            end
            S_WL_CHK: begin
                if (!phase_reg) begin
                    prev_next = rdata_reg;
                    rd_en = 1'b1;
                    raddr = AW'(cur_reg - 8'd1);
                    phase_next = 1'b1;
                end else if (prev_reg != CH_SP && rdata_reg == CH_SP) begin
                    act_next = ACT_LEFT;
                    cnt_next = n_reg;
                    st_next  = S_DONE;
                end else begin
                    st_next = S_WL_RD;
                end
            end
            S_DONE: begin
                st_next = S_IDLE;
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    assign stat.done   = (st_reg == S_DONE);
    assign stat.action = act_reg;
    assign stat.count  = cnt_reg;
    assign stat.ch     = och_reg;
    assign stat.length = len_reg;
    assign stat.cursor = cur_reg;
endmodule

/* src/ale_control.sv */
// ale_control: escape parser, arm and timeout control, and the request handshake
// depends on ale_pkg; drives ale_datapath through dp_cmd_t
module ale_control
    import ale_pkg::*;
#(
    parameter int PARAM_SLOTS = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [31:0] ctrl_mask,
    input  logic [31:0] idle_limit,
    input  in_item_t   s_item,
    input  logic       s_valid,
    output logic       s_ready,
    output out_item_t  m_item,
    output logic       m_valid,
    input  logic       m_ready,
    output dp_cmd_t    cmd,
    input  dp_stat_t   stat
);
    localparam int CW = $clog2(PARAM_SLOTS + 1);

    typedef enum logic [1:0] {C_IDLE, C_BUSY, C_OUT} cst_t;

    cst_t        st_reg;
    esc_t        esc_reg;
    logic [15:0] p0_reg, p1_reg;
    logic [CW-1:0] cnt_reg;
    logic        armed_reg;
    logic [31:0] idle_reg;
    dp_cmd_t     cmd_reg;
    out_item_t   out_reg;
    logic        immediate_reg;
    action_t     imm_act_reg;
    logic [7:0]  imm_ch_reg;

    esc_t        esc_n;
    logic [15:0] p0_n, p1_n;
    logic [CW-1:0] cnt_n;
    logic        armed_n;
    logic [31:0] idle_n;
    op_t         op_n;
    logic [8:0]  amt_n;
    action_t     iact_n;
    logic [7:0]  ich_n;
    logic [7:0]  d;
    logic [15:0] digit_val;
    logic [CW-1:0] cnt_fin;

    assign d = s_item.data;
    assign digit_val = 16'(p0_reg * 16'd10) + 16'(d - 8'h30);

    always_comb begin
        esc_n   = esc_reg;
        p0_n    = p0_reg;
        p1_n    = p1_reg;
        cnt_n   = cnt_reg;
        armed_n = armed_reg;
        idle_n  = idle_reg;
        op_n    = OP_NONE;
        amt_n   = '0;
        iact_n  = ACT_NONE;
        ich_n   = '0;
        cnt_fin = (cnt_reg == CW'(PARAM_SLOTS)) ? cnt_reg : cnt_reg + CW'(1);
        case (s_item.func)
            FUNC_BYTE: begin
                if (armed_reg) begin
                    idle_n = '0;
                    if (d == CH_CAN) begin
                        esc_n = ESC_C0;
                    end else begin
                        case (esc_reg)
                            ESC_C0: begin
                                if (d < 8'd32 && ctrl_mask[d[4:0]]) begin
                                    armed_n = 1'b0;
                                    op_n = OP_CTRL;
                                end else if (d == CH_CR) begin
                                    armed_n = 1'b0;
                                    iact_n = ACT_LINE;
                                    ich_n = CH_CR;
                                end else if (d == CH_ESC) begin
                                    esc_n = ESC_FE;
                                end else if (d == CH_BS || d == CH_DEL) begin
                                    op_n = OP_BACK;
                                end else if (d == 8'd1) begin
                                    op_n = OP_LEFT; amt_n = 9'd256;
                                end else if (d == 8'd2) begin
                                    op_n = OP_LEFT; amt_n = 9'd1;
                                end else if (d == 8'd5) begin
                                    op_n = OP_RIGHT; amt_n = 9'd256;
                                end else if (d == 8'd6) begin
                                    op_n = OP_RIGHT; amt_n = 9'd1;
                                end else if (d >= CH_SP) begin
                                    op_n = OP_INSERT;
                                end
                            end
                            ESC_FE: begin
                                esc_n = ESC_C0;
                                if (d == "[") begin
                                    esc_n = ESC_CSI;
                                    cnt_n = '0;
                                    p0_n  = '0;
                                end else if (d == "b" || d == 8'd2) begin
                                    op_n = OP_WLEFT;
                                end else if (d == "f" || d == 8'd6) begin
                                    op_n = OP_WRIGHT;
                                end else if (d == "N") begin
                                    esc_n = ESC_SS2;
                                end else if (d == "O") begin
                                    esc_n = ESC_SS3;
                                end else if (d == CH_DEL) begin
                                    op_n = OP_DEL;
                                end
                            end
                            ESC_SS2: begin
                                esc_n = ESC_C0;
                            end
                            ESC_SS3: begin
                                esc_n = ESC_C0;
                                if (d == "F") begin
                                    op_n = OP_RIGHT; amt_n = 9'd256;
                                end else if (d == "H") begin
                                    op_n = OP_LEFT; amt_n = 9'd256;
                                end
                            end
                            default: begin
                                if (d >= "0" && d <= "9") begin
                                    if (cnt_reg == '0) begin
                                        p0_n = digit_val;
                                    end else if (cnt_reg == CW'(1)) begin
                                        p1_n = 16'(p1_reg * 16'd10) + 16'(d - 8'h30);
                                    end
                                end else if (d == ";" || d == ":") begin
                                    cnt_n = cnt_fin;
                                    if (cnt_reg == '0) begin
                                        p1_n = '0;
                                    end
                                end else if (d == "<" || d == "=" || d == ">" || d == "?") begin
                                    esc_n = ESC_PRIV;
                                end else if (esc_reg == ESC_PRIV) begin
                                    esc_n = ESC_C0;
                                end else begin
                                    esc_n = ESC_C0;
                                    cnt_n = cnt_fin;
                                    if (d == "C" || d == "D") begin
                                        if (cnt_fin > CW'(1) && p1_reg != 16'd1) begin
                                            op_n = (d == "C") ? OP_WRIGHT : OP_WLEFT;
                                        end else begin
                                            op_n = (d == "C") ? OP_RIGHT : OP_LEFT;
                                            amt_n = (p0_reg == 16'd0) ? 9'd1 :
                                                (p0_reg > 16'd256) ? 9'd256 : p0_reg[8:0];
                                        end
                                    end else if (d == "F") begin
                                        op_n = OP_RIGHT; amt_n = 9'd256;
                                    end else if (d == "H") begin
                                        op_n = OP_LEFT; amt_n = 9'd256;
                                    end else if (d == "b" || d == 8'd2) begin
                                        op_n = OP_WLEFT;
                                    end else if (d == "f" || d == 8'd6) begin
                                        op_n = OP_WRIGHT;
                                    end else if (d == "~") begin
                                        if (p0_reg == 16'd1 || p0_reg == 16'd7) begin
                                            op_n = OP_LEFT; amt_n = 9'd256;
                                        end else if (p0_reg == 16'd4 || p0_reg == 16'd8) begin
                                            op_n = OP_RIGHT; amt_n = 9'd256;
                                        end else if (p0_reg == 16'd3) begin
                                            op_n = OP_DEL;
                                        end
                                    end
                                end
                            end
                        endcase
                    end
                end
            end
            FUNC_TICK: begin
                if (armed_reg && idle_limit != 32'd0) begin
                    if (idle_reg != 32'hFFFF_FFFF) begin
                        idle_n = idle_reg + 32'd1;
                    end
                    if (idle_n > idle_limit) begin
                        armed_n = 1'b0;
                        iact_n = ACT_TIMEOUT;
                    end
                end
            end
            FUNC_ARM: begin
                esc_n = ESC_C0;
                idle_n = '0;
                armed_n = 1'b1;
                op_n = OP_ARM;
            end
            FUNC_CANCEL: begin
                armed_n = 1'b0;
            end
            FUNC_READ: begin
                op_n = OP_READ;
            end
            default: begin
                op_n = OP_NONE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= C_IDLE;
            esc_reg   <= ESC_C0;
            cnt_reg   <= '0;
            armed_reg <= 1'b0;
            idle_reg  <= '0;
            cmd_reg.start <= 1'b0;
        end else begin
            cmd_reg.start <= 1'b0;
            case (st_reg)
                C_IDLE: begin
                    if (s_valid) begin
                        esc_reg   <= esc_n;
                        p0_reg    <= p0_n;
                        p1_reg    <= p1_n;
                        cnt_reg   <= cnt_n;
                        armed_reg <= armed_n;
                        idle_reg  <= idle_n;
                        cmd_reg.start <= 1'b1;
                        cmd_reg.op    <= op_n;
                        cmd_reg.amount <= amt_n;
                        cmd_reg.ch    <= d;
                        cmd_reg.index <= s_item.index;
                        imm_act_reg <= iact_n;
                        imm_ch_reg  <= ich_n;
                        immediate_reg <= (op_n == OP_NONE);
                        st_reg <= C_BUSY;
                    end
                end
                C_BUSY: begin
                    if (stat.done) begin
                        out_reg.action <= immediate_reg ? imm_act_reg : stat.action;
                        out_reg.count  <= immediate_reg ? 9'd0 : stat.count;
                        out_reg.char_value <= immediate_reg ? imm_ch_reg : stat.ch;
                        out_reg.line_length <= stat.length;
                        out_reg.cursor <= stat.cursor;
                        out_reg.active <= armed_reg;
                        st_reg <= C_OUT;
                    end
                end
                C_OUT: begin
                    if (m_ready) begin
                        st_reg <= C_IDLE;
                    end
                end
                default: begin
                    st_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (st_reg == C_IDLE);
    assign m_valid = (st_reg == C_OUT);
    assign m_item  = out_reg;
    assign cmd     = cmd_reg;
endmodule

/* src/ansi_line_editor.sv */
// ansi_line_editor: top level with the configuration registers and the APB-style port
// depends on ale_pkg, ale_control and ale_datapath
//
// Terminal line editor: each request (byte, tick, arm, cancel or store read) yields one
// result naming an edit action. On the line store a read adds a state, an insert or
// delete shifts the bytes one at a time with a read and then a write for each, and a word
// move reads and checks the store position by position. One request is handled at a time;
// the next is taken once the result has been delivered.
module ansi_line_editor
    import ale_pkg::*;
#(
    parameter int LINE_DEPTH  = 256,
    parameter int PARAM_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  in_item_t    s_item,
    input  logic        s_valid,
    output logic        s_ready,
    output out_item_t   m_item,
    output logic        m_valid,
    input  logic        m_ready
);
    logic [8:0]  line_size_reg;
    logic [31:0] ctrl_mask_reg;
    logic [31:0] timeout_reg;
    logic [8:0]  capacity;
    logic [1:0]  reg_idx;
    dp_cmd_t     cmd;
    dp_stat_t    stat;

    assign reg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_size_reg <= 9'd256;
            ctrl_mask_reg <= '0;
            timeout_reg   <= '0;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_LINE_SIZE:  line_size_reg <= pwdata[8:0];
                REG_CTRL_MASK:  ctrl_mask_reg <= pwdata;
                REG_IDLE_LIMIT: timeout_reg   <= pwdata;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_LINE_SIZE:  prdata = {23'd0, line_size_reg};
            REG_CTRL_MASK:  prdata = ctrl_mask_reg;
            REG_IDLE_LIMIT: prdata = timeout_reg;
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (line_size_reg == 9'd0) begin
            capacity = '0;
        end else if (32'(line_size_reg) > LINE_DEPTH) begin
            capacity = 9'(LINE_DEPTH - 1);
        end else begin
            capacity = line_size_reg - 9'd1;
        end
    end

    ale_control #(.PARAM_SLOTS(PARAM_SLOTS)) u_ctrl (
        .aclk, .aresetn,
        .ctrl_mask(ctrl_mask_reg), .idle_limit(timeout_reg),
        .s_item, .s_valid, .s_ready, .m_item, .m_valid, .m_ready,
        .cmd, .stat
    );

    ale_datapath #(.LINE_DEPTH(LINE_DEPTH)) u_dp (
        .aclk, .aresetn, .capacity, .cmd, .stat
    );
endmodule

/* src/ale_checker.sv */
// ale_checker: port-level assertions for ansi_line_editor, bound to the top level
// depends on ale_pkg
module ale_checker
    import ale_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("request taken while result pending");
    a_action_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.action <= ACT_READ)
        else $error("bad action");
    a_s_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("request dropped before accept");
endmodule

bind ansi_line_editor ale_checker u_chk (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready, .m_item
);

/* dv/tb_top.sv */
// tb_top: self-checking testbench for ansi_line_editor, with an in-bench line editor predictor
// drives requests and register writes, compares every result field by field
// depends on ale_pkg and the ansi_line_editor rtl
module tb_top;
    import ale_pkg::*;

    localparam int DEPTH = 256;
    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 2000000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    in_item_t    s_item = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    out_item_t   m_item;
    logic        m_valid;
    logic        m_ready = 1'b0;

    ansi_line_editor dut (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_item(s_item), .s_valid(s_valid), .s_ready(s_ready),
        .m_item(m_item), .m_valid(m_valid), .m_ready(m_ready)
    );

    always #1 aclk = ~aclk;

    // editor state mirror
    logic [8:0]  cfg_size = 9'd256;
    logic [31:0] cfg_mask = '0;
    logic [31:0] cfg_timeout = '0;
    logic [7:0]  store [DEPTH];
    int unsigned len_m, cur_m, csi_cnt;
    esc_t        esc_m;
    logic [15:0] params [SLOTS];
    bit          armed_m;
    logic [31:0] idle_m;
    action_t     r_act;
    int unsigned r_cnt;
    logic [7:0]  r_ch;

    out_item_t   expected_results [$];
    int          errors = 0;
    int          results_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;
    longint      cycle_count = 0;

    function automatic void note(action_t a, int unsigned n, logic [7:0] c);
        r_act = a; r_cnt = n; r_ch = c;
    endfunction

    function automatic int unsigned room();
        int unsigned s;
        s = cfg_size;
        if (s < 1) s = 1;
        if (s > DEPTH) s = DEPTH;
        return s - 1;
    endfunction

    function automatic void move_left(int unsigned n);
        if (n > cur_m) n = cur_m;
        if (n == 0) return;
        cur_m -= n;
        note(ACT_LEFT, n, 8'd0);
    endfunction

    function automatic void move_right(int unsigned n);
        if (n > len_m - cur_m) n = len_m - cur_m;
        if (n == 0) return;
        cur_m += n;
        note(ACT_RIGHT, n, 8'd0);
    endfunction

    function automatic void word_fwd();
        int unsigned n;
        n = 0;
        while (cur_m < len_m) begin
            n++;
            cur_m++;
            if (cur_m >= len_m) break;
            if (store[cur_m] == CH_SP && store[cur_m-1] != CH_SP) break;
        end
        if (n != 0) note(ACT_RIGHT, n, 8'd0);
    endfunction

    function automatic void word_back();
        int unsigned n;
        n = 0;
        while (cur_m > 0) begin
            n++;
            cur_m--;
            if (cur_m == 0) break;
            if (store[cur_m] != CH_SP && store[cur_m-1] == CH_SP) break;
        end
        if (n != 0) note(ACT_LEFT, n, 8'd0);
    endfunction

    function automatic void cut_at(int unsigned p);
        len_m--;
        for (int unsigned i = p; i < len_m; i++) store[i] = store[i+1];
    endfunction

    function automatic void delete_here();
        if (len_m == 0 || cur_m >= len_m) return;
        cut_at(cur_m);
        note(ACT_DELETE, 0, 8'd0);
    endfunction

    function automatic void rubout();
        if (cur_m == 0 || len_m == 0) return;
        cur_m--;
        cut_at(cur_m);
        note(ACT_BACK, 0, 8'd0);
    endfunction

    function automatic void put_char(logic [7:0] c);
        if (c < 32 || len_m >= room()) return;
        for (int unsigned i = len_m; i > cur_m; i--) store[i] = store[i-1];
        len_m++;
        store[cur_m] = c;
        note(ACT_INSERT, len_m - cur_m, c);
        cur_m++;
    endfunction

    function automatic int unsigned param_at(int unsigned k);
        return (k < SLOTS) ? params[k] : 0;
    endfunction

    function automatic void csi_final(logic [7:0] c);
        int unsigned n, p;
        esc_m = ESC_C0;
        csi_cnt++;
        if (csi_cnt > SLOTS) csi_cnt = SLOTS;
        if (c == "C" || c == "D") begin
            n = param_at(0);
            if (n < 1) n = 1;
            if (csi_cnt > 1 && param_at(1) != 1) begin
                if (c == "C") word_fwd(); else word_back();
            end else if (c == "C") move_right(n);
            else move_left(n);
        end else if (c == "F") move_right(len_m - cur_m);
        else if (c == "H") move_left(cur_m);
        else if (c == "b" || c == 8'd2) word_back();
        else if (c == "f" || c == 8'd6) word_fwd();
        else if (c == "~") begin
            p = param_at(0);
            if (p == 1 || p == 7) move_left(cur_m);
            else if (p == 4 || p == 8) move_right(len_m - cur_m);
            else if (p == 3) delete_here();
        end
    endfunction

    function automatic void take_byte(logic [7:0] c);
        if (c == CH_CAN) begin
            esc_m = ESC_C0;
            return;
        end
        case (esc_m)
            ESC_C0: begin
                if (c < 32 && cfg_mask[c[4:0]]) begin
                    store[0] = c;
                    len_m = 1;
                    armed_m = 0;
                    note(ACT_CTRL, 0, c);
                end else if (c == CH_CR) begin
                    armed_m = 0;
                    note(ACT_LINE, 0, CH_CR);
                end else if (c == CH_ESC) esc_m = ESC_FE;
                else if (c == CH_BS || c == CH_DEL) rubout();
                else if (c == 8'd1) move_left(cur_m);
                else if (c == 8'd2) move_left(1);
                else if (c == 8'd5) move_right(len_m - cur_m);
                else if (c == 8'd6) move_right(1);
                else put_char(c);
            end
            ESC_FE: begin
                esc_m = ESC_C0;
                if (c == "[") begin
                    esc_m = ESC_CSI;
                    csi_cnt = 0;
                    params[0] = 0;
                end else if (c == "b" || c == 8'd2) word_back();
                else if (c == "f" || c == 8'd6) word_fwd();
                else if (c == "N") esc_m = ESC_SS2;
                else if (c == "O") esc_m = ESC_SS3;
                else if (c == CH_DEL) delete_here();
            end
            ESC_SS2: esc_m = ESC_C0;
            ESC_SS3: begin
                esc_m = ESC_C0;
                if (c == "F") move_right(len_m - cur_m);
                else if (c == "H") move_left(cur_m);
            end
            default: begin
                if (c >= "0" && c <= "9") begin
                    if (csi_cnt < SLOTS) params[csi_cnt] = params[csi_cnt] * 16'd10 + (c - "0");
                end else if (c == ";" || c == ":") begin
                    csi_cnt++;
                    if (csi_cnt < SLOTS) params[csi_cnt] = 0;
                    else csi_cnt = SLOTS;
                end else if (c == "<" || c == "=" || c == ">" || c == "?") esc_m = ESC_PRIV;
                else if (esc_m == ESC_PRIV) esc_m = ESC_C0;
                else csi_final(c);
            end
        endcase
    endfunction

    function automatic out_item_t predict_edit(in_item_t it);
        out_item_t o;
        note(ACT_NONE, 0, 8'd0);
        case (it.func)
            FUNC_BYTE: if (armed_m) begin
                idle_m = 0;
                take_byte(it.data);
            end
            FUNC_TICK: if (armed_m && cfg_timeout != 0) begin
                if (idle_m != 32'hFFFF_FFFF) idle_m++;
                if (idle_m > cfg_timeout) begin
                    armed_m = 0;
                    note(ACT_TIMEOUT, 0, 8'd0);
                end
            end
            FUNC_ARM: begin
                len_m = 0; cur_m = 0; esc_m = ESC_C0; idle_m = 0; armed_m = 1;
            end
            FUNC_CANCEL: armed_m = 0;
            FUNC_READ: note(ACT_READ, 0, store[it.index]);
            default: ;
        endcase
        o.action = r_act;
        o.count = r_cnt[8:0];
        o.char_value = r_ch;
        o.line_length = len_m[7:0];
        o.cursor = cur_m[7:0];
        o.active = armed_m;
        return o;
    endfunction

    // one above the highest store entry written so far, reads stay below it
    int written_top = 0;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // receiver stall and result check
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result %p", $realtime, m_item);
                end else begin
                    out_item_t e;
                    e = expected_results.pop_front();
                    if (e.action !== m_item.action || e.count !== m_item.count ||
                        e.char_value !== m_item.char_value ||
                        e.line_length !== m_item.line_length ||
                        e.cursor !== m_item.cursor || e.active !== m_item.active) begin
                        errors++;
                        $display("%0t mismatch expected %p actual %p", $realtime, e, m_item);
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_ready <= 1'b0;
            end else m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(in_item_t it);
        if (it.func == FUNC_READ && it.index >= written_top)
            it.index = 8'($urandom_range(written_top - 1));
        if (it.func == FUNC_READ && written_top == 0) it.func = FUNC_CANCEL;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_item <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(predict_edit(it));
        if (len_m > written_top) written_top = len_m;
    endtask

    task automatic send_byte(logic [7:0] b);
        in_item_t it;
        it.func = FUNC_BYTE; it.data = b; it.index = 8'($urandom);
        send_request(it);
    endtask

    task automatic send_op(func_t f, logic [7:0] idx = 0);
        in_item_t it;
        it.func = f; it.data = 8'($urandom); it.index = idx;
        send_request(it);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (2 * DEPTH + 20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] r, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {r, 2'b00}; pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (r)
            REG_LINE_SIZE: cfg_size = v[8:0];
            REG_CTRL_MASK: cfg_mask = v;
            REG_IDLE_LIMIT: cfg_timeout = v;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic test_directed();
        send_byte("x");
        send_op(FUNC_TICK);
        send_op(FUNC_ARM);
        send_byte("a"); send_byte("b"); send_byte(" "); send_byte("c"); send_byte("d");
        send_byte("a"); send_byte(" "); send_byte(8'd200); send_byte(8'd255);
        send_byte(8'd1); send_byte(8'd6); send_byte(8'd5); send_byte(8'd2);
        send_byte(CH_BS); send_byte(CH_DEL);
        send_byte(CH_ESC); send_byte("b"); send_byte(CH_ESC); send_byte("f");
        send_byte(CH_ESC); send_byte(CH_DEL);
        send_byte(CH_ESC); send_byte("["); send_byte("3"); send_byte(";");
        send_byte("5"); send_byte("D");
        send_byte(CH_ESC); send_byte("["); send_byte("?"); send_byte("h");
        send_byte(CH_ESC); send_byte("O"); send_byte("H");
        send_byte(CH_ESC); send_byte("["); send_byte(CH_CAN); send_byte("z");
        send_op(FUNC_READ, 8'd0); send_op(FUNC_READ, 8'd255);
        send_byte(CH_CR);
        send_op(FUNC_CANCEL);
        begin
            in_item_t it;
            it.func = 3'd7; it.data = 8'hFF; it.index = 8'hFF;
            send_request(it);
        end
        drain();
    endtask

    task automatic random_bytes(int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(9))
                0: send_op(func_t'($urandom_range(4)), 8'($urandom));
                1, 2: begin
                    send_byte(CH_ESC);
                    case ($urandom_range(3))
                        0: send_byte("[");
                        1: send_byte(8'($urandom));
                        2: send_byte("O");
                        default: send_byte("N");
                    endcase
                    if (esc_m == ESC_CSI) begin
                        repeat ($urandom_range(4)) begin
                            if ($urandom_range(3) == 0) send_byte(";");
                            else send_byte(8'("0" + $urandom_range(9)));
                        end
                        case ($urandom_range(9))
                            0: send_byte("C"); 1: send_byte("D"); 2: send_byte("F");
                            3: send_byte("H"); 4: send_byte("~"); 5: send_byte("b");
                            6: send_byte("f"); 7: send_byte("?");
                            default: send_byte(8'($urandom));
                        endcase
                    end else begin
                        case ($urandom_range(3))
                            0: send_byte("F");
                            1: send_byte("H");
                            2: send_byte("b");
                            default: send_byte("f");
                        endcase
                    end
                end
                3: send_byte(8'($urandom_range(31)));
                4: send_byte(" ");
                default: send_byte(8'($urandom_range(33, 255)));
            endcase
            if (!armed_m) send_op(FUNC_ARM);
        end
    endtask

    task automatic test_random();
        int pct [4][2] = '{'{0, 0}, '{50, 0}, '{0, 50}, '{20, 20}};
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = pct[ph][0];
            recv_stall_pct = pct[ph][1];
            write_reg(REG_LINE_SIZE, (ph == 0) ? 9'd511 : (ph == 1) ? 9'd0 :
                      (ph == 2) ? 9'd8 : 9'($urandom_range(2, 256)));
            write_reg(REG_CTRL_MASK, (ph == 3) ? 32'hFFFF_FFFF : $urandom & ~32'h0100_2000);
            send_op(FUNC_ARM);
            random_bytes(110);
            drain();
        end
    endtask

    task automatic test_timeout();
        write_reg(REG_IDLE_LIMIT, 32'd3);
        send_op(FUNC_ARM);
        repeat (3) send_op(FUNC_TICK);
        send_byte("q");
        repeat (5) send_op(FUNC_TICK);
        send_op(FUNC_ARM);
        drain();
        write_reg(REG_IDLE_LIMIT, 32'hFFFF_FFFF);
        repeat (4) send_op(FUNC_TICK);
        drain();
        write_reg(REG_IDLE_LIMIT, 32'd0);
        drain();
    endtask

    task automatic test_backpressure();
        write_reg(REG_LINE_SIZE, 9'd256);
        write_reg(REG_CTRL_MASK, 32'd0);
        send_op(FUNC_ARM);
        hold_cycles = 400;
        for (int i = 0; i < 80; i++) send_byte(8'($urandom_range(32, 255)));
        send_op(FUNC_READ, 8'd0);
        drain();
    endtask

    initial begin
        for (int i = 0; i < DEPTH; i++) store[i] = 8'd0;
        for (int i = 0; i < SLOTS; i++) params[i] = '0;
        len_m = 0; cur_m = 0; esc_m = ESC_C0; csi_cnt = 0; armed_m = 0; idle_m = 0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_timeout();
        test_random();
        test_backpressure();
        $display("covered directed edits, escape sequences, timeouts, %0d results", results_seen);
        $display("register extremes and four idle and stall mixes including a long hold-off");
        if (errors == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end
endmodule

/* filelist.f */
src/ale_pkg.sv
src/ale_datapath.sv
src/ale_control.sv
src/ansi_line_editor.sv
src/ale_checker.sv
dv/tb_top.sv
